### src/lpcp_pkg.sv
// Package for the LiDAR point to camera projection block.
// Register indexes, reset values, fixed-point widths and constants; no dependencies.
`default_nettype none
package lpcp_pkg;
    localparam int PT_W      = 24;
    localparam int CFG_W     = 16;
    localparam int SIDE_W    = 13;
    localparam int PIX_W     = 12;
    localparam int ROT_FRAC  = 14;
    localparam int PIX_FRAC  = 4;
    localparam int PROD_W    = 40;
    localparam int SUM_W     = 41;
    localparam int ROT_W     = SUM_W - ROT_FRAC;
    localparam int CAMZ_W    = ROT_W + 1;
    localparam int CAMY_W    = PT_W + 1;
    localparam int DEN_W     = 26;
    localparam int NUM_W     = 42;
    localparam int DEF_MAX_IMAGE_SIDE = 4096;
    localparam int CAM_OFFSET_Q8      = 384;

    typedef enum logic [2:0] {
        REG_COS_YAW  = 3'd0,
        REG_SIN_YAW  = 3'd1,
        REG_FOCAL_X  = 3'd2,
        REG_FOCAL_Y  = 3'd3,
        REG_CENTER_X = 3'd4,
        REG_CENTER_Y = 3'd5,
        REG_IMG_W    = 3'd6,
        REG_IMG_H    = 3'd7
    } t_reg_idx;

    localparam logic [CFG_W-1:0]  RST_COS_YAW  = 16'd16384;
    localparam logic [CFG_W-1:0]  RST_SIN_YAW  = 16'd0;
    localparam logic [CFG_W-1:0]  RST_FOCAL_X  = 16'd5120;
    localparam logic [CFG_W-1:0]  RST_FOCAL_Y  = 16'd5120;
    localparam logic [CFG_W-1:0]  RST_CENTER_X = 16'd5120;
    localparam logic [CFG_W-1:0]  RST_CENTER_Y = 16'd3840;
    localparam logic [SIDE_W-1:0] RST_IMG_W    = 13'd640;
    localparam logic [SIDE_W-1:0] RST_IMG_H    = 13'd480;
endpackage
`default_nettype wire

### src/lpcp_div.sv
// Pipelined restoring divider, one quotient bit per stage, with payload.
// Unsigned magnitude in, quotient and remainder-nonzero flag out; no dependencies.
`default_nettype none
module lpcp_div #(
    parameter int NW = 42,
    parameter int DW = 26,
    parameter int PW = 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    input  wire logic [PW-1:0] i_pay,
    output logic               o_valid,
    output logic [NW-1:0]      o_quo,
    output logic               o_rem_nz,
    output logic [PW-1:0]      o_pay
);
    logic          r_vld [NW];
    logic [NW-1:0] r_nq  [NW];
    logic [DW-1:0] r_rem [NW];
    logic [DW-1:0] r_den [NW];
    logic [PW-1:0] r_pay [NW];

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic          p_vld;
        logic [NW-1:0] p_nq;
        logic [DW-1:0] p_rem;
        logic [DW-1:0] p_den;
        logic [PW-1:0] p_pay;
        logic [DW:0]   rem_sh;
        logic [DW:0]   diff;
        logic          ge;
        if (k == 0) begin : g_first
            assign p_vld = i_valid;
            assign p_nq  = i_num;
            assign p_rem = '0;
            assign p_den = i_den;
            assign p_pay = i_pay;
        end else begin : g_rest
            assign p_vld = r_vld[k-1];
            assign p_nq  = r_nq[k-1];
            assign p_rem = r_rem[k-1];
            assign p_den = r_den[k-1];
            assign p_pay = r_pay[k-1];
        end
        assign rem_sh = {p_rem, p_nq[NW-1]};
        assign ge     = rem_sh >= {1'b0, p_den};
        assign diff   = rem_sh - {1'b0, p_den};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_nq[k]  <= {p_nq[NW-2:0], ge};
                r_rem[k] <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
                r_den[k] <= p_den;
                r_pay[k] <= p_pay;
            end
        end
    end

    assign o_valid  = r_vld[NW-1];
    assign o_quo    = r_nq[NW-1];
    assign o_rem_nz = |r_rem[NW-1];
    assign o_pay    = r_pay[NW-1];
endmodule
`default_nettype wire

### src/lpcp_front.sv
// Front end: yaw rotation, camera offset, focal products and sign/magnitude split.
// Four register stages; uses lpcp_pkg.
`default_nettype none
module lpcp_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_valid,
    input  wire logic signed [lpcp_pkg::PT_W-1:0]  i_x,
    input  wire logic signed [lpcp_pkg::PT_W-1:0]  i_y,
    input  wire logic signed [lpcp_pkg::PT_W-1:0]  i_z,
    input  wire logic signed [lpcp_pkg::CFG_W-1:0] i_cos,
    input  wire logic signed [lpcp_pkg::CFG_W-1:0] i_sin,
    input  wire logic [lpcp_pkg::CFG_W-1:0]        i_fx,
    input  wire logic [lpcp_pkg::CFG_W-1:0]        i_fy,
    output logic                               o_valid,
    output logic [lpcp_pkg::NUM_W-1:0]         o_num_u,
    output logic [lpcp_pkg::NUM_W-1:0]         o_num_v,
    output logic                               o_neg_u,
    output logic                               o_neg_v,
    output logic [lpcp_pkg::DEN_W-1:0]         o_den,
    output logic [3*lpcp_pkg::PT_W-1:0]        o_orig
);
    import lpcp_pkg::*;

    localparam int NU_W = NUM_W + 2;
    localparam int NV_W = CFG_W + 1 + CAMY_W;

    logic                     r_v1, r_v2, r_v3, r_v4;
    logic [3*PT_W-1:0]        r_o1, r_o2, r_o3, r_o4;
    logic signed [PROD_W-1:0] r_cx, r_sy, r_sx, r_cy;
    logic signed [PT_W-1:0]   r_z1;
    logic signed [CAMZ_W-1:0] r_camz;
    logic signed [ROT_W-1:0]  r_camx;
    logic signed [CAMY_W-1:0] r_camy;
    logic signed [NU_W-1:0]   r_nu;
    logic signed [NV_W-1:0]   r_nv;
    logic [DEN_W-1:0]         r_den3, r_den4;
    logic [NUM_W-1:0]         r_mu, r_mv;
    logic                     r_su, r_sv;

    logic signed [SUM_W-1:0]  sum_rx, sum_ry;
    logic signed [NU_W-1:0]   abs_u;
    logic signed [NV_W-1:0]   abs_v;

    assign sum_rx = SUM_W'(r_cx) - SUM_W'(r_sy);
    assign sum_ry = SUM_W'(r_sx) + SUM_W'(r_cy);
    assign abs_u  = r_nu[NU_W-1] ? -r_nu : r_nu;
    assign abs_v  = r_nv[NV_W-1] ? -r_nv : r_nv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2 && (r_camz > 0);
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cx   <= PROD_W'(i_cos * i_x);
            r_sy   <= PROD_W'(i_sin * i_y);
            r_sx   <= PROD_W'(i_sin * i_x);
            r_cy   <= PROD_W'(i_cos * i_y);
            r_z1   <= i_z;
            r_o1   <= {i_x, i_y, i_z};
            r_camz <= CAMZ_W'($signed(sum_rx[SUM_W-1:ROT_FRAC])) - CAMZ_W'(CAM_OFFSET_Q8);
            r_camx <= sum_ry[SUM_W-1:ROT_FRAC];
            r_camy <= -CAMY_W'(r_z1);
            r_o2   <= r_o1;
            r_nu   <= NU_W'($signed({1'b0, i_fx}) * r_camx);
            r_nv   <= NV_W'($signed({1'b0, i_fy}) * r_camy);
            r_den3 <= r_camz[DEN_W-1:0];
            r_o3   <= r_o2;
            r_mu   <= abs_u[NUM_W-1:0];
            r_mv   <= NUM_W'(abs_v[NV_W-2:0]);
            r_su   <= r_nu[NU_W-1];
            r_sv   <= r_nv[NV_W-1];
            r_den4 <= r_den3;
            r_o4   <= r_o3;
        end
    end

    assign o_valid = r_v4;
    assign o_num_u = r_mu;
    assign o_num_v = r_mv;
    assign o_neg_u = r_su;
    assign o_neg_v = r_sv;
    assign o_den   = r_den4;
    assign o_orig  = r_o4;
endmodule
`default_nettype wire

### src/lidar_point_camera_projection.sv
// LiDAR point to camera pixel projection, top level.
// Uses lpcp_pkg, lpcp_front and lpcp_div.
// Usage:
//   Input channel i_valid/o_ready carries one point (Q16.8 metres) per
//   transaction; output channel o_valid/i_ready carries a pixel and the
//   original point. Points behind the camera or outside the image give no
//   output transaction.
//   Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx. The user
//   must write only while the block is empty; the block itself has no check.
//   Throughput: one point per cycle while the receiver does not stall. The
//   pipeline is the 42-stage divider (one quotient bit per stage) plus four
//   front stages and two back stages.
//   Reset clears all valid bits and loads register defaults.
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and o_ready falls; nothing is lost or repeated.
`default_nettype none
module lidar_point_camera_projection #(
    parameter int MAX_IMAGE_SIDE = lpcp_pkg::DEF_MAX_IMAGE_SIDE
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire logic signed [lpcp_pkg::PT_W-1:0]   i_point_x,
    input  wire logic signed [lpcp_pkg::PT_W-1:0]   i_point_y,
    input  wire logic signed [lpcp_pkg::PT_W-1:0]   i_point_z,
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output logic [lpcp_pkg::PIX_W-1:0]              o_pixel_col,
    output logic [lpcp_pkg::PIX_W-1:0]              o_pixel_row,
    output logic signed [lpcp_pkg::PT_W-1:0]        o_orig_x,
    output logic signed [lpcp_pkg::PT_W-1:0]        o_orig_y,
    output logic signed [lpcp_pkg::PT_W-1:0]        o_orig_z,
    input  wire logic                               i_cfg_we,
    input  wire logic [2:0]                         i_cfg_idx,
    input  wire logic [lpcp_pkg::CFG_W-1:0]         i_cfg_data
);
    import lpcp_pkg::*;

    localparam int MAX_W = $clog2(MAX_IMAGE_SIDE + 1);
    localparam int CW    = (MAX_W > SIDE_W) ? MAX_W : SIDE_W;
    localparam int Q_W   = NUM_W + 1;
    localparam int U_W   = Q_W + 2;

    logic signed [CFG_W-1:0] r_cos, r_sin;
    logic [CFG_W-1:0]        r_fx, r_fy, r_cxp, r_cyp;
    logic [SIDE_W-1:0]       r_iw, r_ih;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cos <= RST_COS_YAW;
            r_sin <= RST_SIN_YAW;
            r_fx  <= RST_FOCAL_X;
            r_fy  <= RST_FOCAL_Y;
            r_cxp <= RST_CENTER_X;
            r_cyp <= RST_CENTER_Y;
            r_iw  <= RST_IMG_W;
            r_ih  <= RST_IMG_H;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_COS_YAW:  r_cos <= i_cfg_data;
                REG_SIN_YAW:  r_sin <= i_cfg_data;
                REG_FOCAL_X:  r_fx  <= i_cfg_data;
                REG_FOCAL_Y:  r_fy  <= i_cfg_data;
                REG_CENTER_X: r_cxp <= i_cfg_data;
                REG_CENTER_Y: r_cyp <= i_cfg_data;
                REG_IMG_W:    r_iw  <= i_cfg_data[SIDE_W-1:0];
                REG_IMG_H:    r_ih  <= i_cfg_data[SIDE_W-1:0];
                default:      ;
            endcase
        end
    end

    logic en;
    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    logic               f_valid, f_neg_u, f_neg_v;
    logic [NUM_W-1:0]   f_num_u, f_num_v;
    logic [DEN_W-1:0]   f_den;
    logic [3*PT_W-1:0]  f_orig;

    lpcp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_x     (i_point_x),
        .i_y     (i_point_y),
        .i_z     (i_point_z),
        .i_cos   (r_cos),
        .i_sin   (r_sin),
        .i_fx    (r_fx),
        .i_fy    (r_fy),
        .o_valid (f_valid),
        .o_num_u (f_num_u),
        .o_num_v (f_num_v),
        .o_neg_u (f_neg_u),
        .o_neg_v (f_neg_v),
        .o_den   (f_den),
        .o_orig  (f_orig)
    );

    logic               du_valid, dv_valid, du_rnz, dv_rnz, du_neg, dv_neg;
    logic [NUM_W-1:0]   du_q, dv_q;
    logic [3*PT_W-1:0]  du_orig;

    lpcp_div #(.NW(NUM_W), .DW(DEN_W), .PW(3*PT_W + 1)) u_div_u (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (f_valid),
        .i_num    (f_num_u),
        .i_den    (f_den),
        .i_pay    ({f_neg_u, f_orig}),
        .o_valid  (du_valid),
        .o_quo    (du_q),
        .o_rem_nz (du_rnz),
        .o_pay    ({du_neg, du_orig})
    );

    lpcp_div #(.NW(NUM_W), .DW(DEN_W), .PW(1)) u_div_v (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (f_valid),
        .i_num    (f_num_v),
        .i_den    (f_den),
        .i_pay    (f_neg_v),
        .o_valid  (dv_valid),
        .o_quo    (dv_q),
        .o_rem_nz (dv_rnz),
        .o_pay    (dv_neg)
    );

    // floor correction for negative numerators
    logic signed [Q_W-1:0] qu_pos, qv_pos;
    logic signed [Q_W-1:0] r_qu, r_qv;
    logic                  r_v5, r_v6;
    logic [3*PT_W-1:0]     r_o5;

    assign qu_pos = $signed({1'b0, du_q});
    assign qv_pos = $signed({1'b0, dv_q});

    // image bounds
    logic [CW-1:0]         w_cl, h_cl;
    logic signed [U_W-1:0] u_val, v_val, w_lim, h_lim;
    logic                  keep;

    assign w_cl  = (CW'(r_iw) > CW'(MAX_IMAGE_SIDE)) ? CW'(MAX_IMAGE_SIDE) : CW'(r_iw);
    assign h_cl  = (CW'(r_ih) > CW'(MAX_IMAGE_SIDE)) ? CW'(MAX_IMAGE_SIDE) : CW'(r_ih);
    assign w_lim = $signed(U_W'({w_cl, 4'b0000}));
    assign h_lim = $signed(U_W'({h_cl, 4'b0000}));
    assign u_val = U_W'(r_qu) + $signed(U_W'(r_cxp));
    assign v_val = U_W'(r_qv) + $signed(U_W'(r_cyp));
    assign keep  = (u_val >= 0) && (u_val < w_lim) && (v_val >= 0) && (v_val < h_lim);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else if (en) begin
            r_v5 <= du_valid && dv_valid;
            r_v6 <= r_v5 && keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_qu        <= du_neg ? (-qu_pos - Q_W'(du_rnz)) : qu_pos;
            r_qv        <= dv_neg ? (-qv_pos - Q_W'(dv_rnz)) : qv_pos;
            r_o5        <= du_orig;
            o_pixel_col <= u_val[PIX_FRAC +: PIX_W];
            o_pixel_row <= v_val[PIX_FRAC +: PIX_W];
            {o_orig_x, o_orig_y, o_orig_z} <= r_o5;
        end
    end

    assign o_valid = r_v6;

`ifndef SYNTHESIS
    a_ready_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready == (!o_valid || i_ready))
        else $error("ready does not follow output stall");
    a_lanes_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        du_valid == dv_valid)
        else $error("divider lanes out of step");
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (MAX_IMAGE_SIDE <= 4096) |-> CW'(o_pixel_col) < w_cl)
        else $error("column outside image");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_v5) && !$past(en) |-> r_v5 && $stable(r_qu))
        else $error("stage lost during stall");
`endif
endmodule
`default_nettype wire

### verif/tb.sv
// Self-checking testbench for lidar_point_camera_projection.
// Drives points through a valid/ready channel, predicts pixels in fixed point and
// compares every output transaction in order; depends on lpcp_pkg and the RTL only.
module tb;
    import lpcp_pkg::*;

    localparam int LATENCY    = 48;
    localparam int CYCLE_MAX  = 1000000;
    localparam int N_RANDOM   = 1600;

    typedef struct packed {
        logic [PIX_W-1:0] col;
        logic [PIX_W-1:0] row;
        logic [PT_W-1:0]  px;
        logic [PT_W-1:0]  py;
        logic [PT_W-1:0]  pz;
    } t_pixel;

    typedef struct {
        logic [PT_W-1:0] x;
        logic [PT_W-1:0] y;
        logic [PT_W-1:0] z;
        bit              fixed;
        bit              hit;
        logic [PIX_W-1:0] col;
        logic [PIX_W-1:0] row;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic signed [PT_W-1:0] i_point_x = '0, i_point_y = '0, i_point_z = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic [PIX_W-1:0] o_pixel_col, o_pixel_row;
    logic signed [PT_W-1:0] o_orig_x, o_orig_y, o_orig_z;
    logic i_cfg_we = 1'b0;
    logic [2:0] i_cfg_idx = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;

    lidar_point_camera_projection dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    logic [CFG_W-1:0] cam_reg [8];
    t_pixel pixel_q[$];
    int mismatches = 0;
    int cycles = 0;
    bit no_idle = 1'b0;
    bit hold_off = 1'b0;
    bit stim_done = 1'b0;

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        mismatches++;
    endtask

    function automatic longint fdiv(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0) q -= 1;
        return q;
    endfunction

    function automatic bit project(input logic [PT_W-1:0] px, py, pz, output t_pixel p);
        longint x, y, z, c, s, rx, ry, cz, u, v, w, h;
        x = longint'($signed(px));
        y = longint'($signed(py));
        z = longint'($signed(pz));
        c = longint'($signed(cam_reg[REG_COS_YAW]));
        s = longint'($signed(cam_reg[REG_SIN_YAW]));
        rx = (c * x - s * y) >>> ROT_FRAC;
        ry = (s * x + c * y) >>> ROT_FRAC;
        cz = rx - CAM_OFFSET_Q8;
        w = cam_reg[REG_IMG_W][SIDE_W-1:0];
        h = cam_reg[REG_IMG_H][SIDE_W-1:0];
        if (w > DEF_MAX_IMAGE_SIDE) w = DEF_MAX_IMAGE_SIDE;
        if (h > DEF_MAX_IMAGE_SIDE) h = DEF_MAX_IMAGE_SIDE;
        p = '0;
        if (cz <= 0) return 1'b0;
        u = fdiv(longint'(cam_reg[REG_FOCAL_X]) * ry, cz) + longint'(cam_reg[REG_CENTER_X]);
        v = fdiv(longint'(cam_reg[REG_FOCAL_Y]) * (-z), cz) + longint'(cam_reg[REG_CENTER_Y]);
        if (u < 0 || u >= w * 16 || v < 0 || v >= h * 16) return 1'b0;
        p.col = u[PIX_W+PIX_FRAC-1:PIX_FRAC];
        p.row = v[PIX_W+PIX_FRAC-1:PIX_FRAC];
        p.px = px;
        p.py = py;
        p.pz = pz;
        return 1'b1;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_IMG_W || idx == REG_IMG_H) cam_reg[idx] = val & 16'h1FFF;
        else cam_reg[idx] = val;
    endtask

    task automatic wait_empty();
        i_valid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic send_point(input logic [PT_W-1:0] x, y, z, input t_row r);
        t_pixel p;
        bit hit;
        while (!no_idle && $urandom_range(99) < 29) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_point_x <= x;
        i_point_y <= y;
        i_point_z <= z;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        hit = project(x, y, z, p);
        if (r.fixed) begin
            if (hit != r.hit) report("table hit", hit, r.hit);
            else if (hit && (p.col != r.col || p.row != r.row))
                report("table pixel", {p.col, p.row}, {r.col, r.row});
        end
        if (hit) pixel_q = {pixel_q, p};
    endtask

    function automatic logic [PT_W-1:0] near_coord(int span);
        return PT_W'($signed($urandom_range(2 * span)) - span);
    endfunction

    // receiver with random stalls
    always @(posedge i_clk) begin
        if (!i_rst_n || hold_off) i_ready <= 1'b0;
        else i_ready <= no_idle || ($urandom_range(99) >= 29);
    end

    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pixel_q.size() == 0) begin
                report("unexpected transaction", o_pixel_col, -1);
            end else begin
                want = pixel_q.pop_front();
                if (o_pixel_col != want.col) report("pixel_col", o_pixel_col, want.col);
                if (o_pixel_row != want.row) report("pixel_row", o_pixel_row, want.row);
                if (o_orig_x != want.px) report("orig_x", o_orig_x, $signed(want.px));
                if (o_orig_y != want.py) report("orig_y", o_orig_y, $signed(want.py));
                if (o_orig_z != want.pz) report("orig_z", o_orig_z, $signed(want.pz));
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_MAX) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    t_row dir_tab [] = '{
        '{24'd2560, 24'd0, 24'd0, 1, 1, 12'd320, 12'd240},
        '{24'd384, 24'd0, 24'd0, 1, 0, 12'd0, 12'd0},
        '{24'd385, 24'd0, 24'd0, 1, 1, 12'd320, 12'd240},
        '{24'hFFF000, 24'd0, 24'd0, 1, 0, 12'd0, 12'd0},
        '{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1, 0, 12'd0, 12'd0},
        '{24'h7FFFFF, 24'd0, 24'd0, 1, 1, 12'd320, 12'd240},
        '{24'h800000, 24'h800000, 24'h800000, 1, 0, 12'd0, 12'd0},
        '{24'd2560, 24'hFFFF00, 24'd256, 0, 0, 0, 0},
        '{24'd5000, 24'd1200, 24'hFFFA00, 0, 0, 0, 0},
        '{24'd1000, 24'h800000, 24'd0, 0, 0, 0, 0},
        '{24'd3000, 24'd0, 24'h7FFFFF, 0, 0, 0, 0},
        '{24'd20000, 24'd4000, 24'd3000, 0, 0, 0, 0}
    };

    initial begin
        t_row blank;
        logic [CFG_W-1:0] cfg;
        blank = '{0, 0, 0, 0, 0, 0, 0};
        cam_reg = '{RST_COS_YAW, RST_SIN_YAW, RST_FOCAL_X, RST_FOCAL_Y,
                    RST_CENTER_X, RST_CENTER_Y, 16'(RST_IMG_W), 16'(RST_IMG_H)};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (dir_tab[i]) send_point(dir_tab[i].x, dir_tab[i].y, dir_tab[i].z, dir_tab[i]);
        wait_empty();
        // zero-size image, then oversized
        write_reg(REG_IMG_W, 16'd0);
        send_point(24'd2560, 24'd0, 24'd0, '{0, 0, 0, 1, 0, 0, 0});
        wait_empty();
        write_reg(REG_IMG_W, 16'h1FFF);
        write_reg(REG_IMG_H, 16'd8191);
        write_reg(REG_CENTER_X, 16'hFFFF);
        write_reg(REG_CENTER_Y, 16'hFFFF);
        send_point(24'd2560, 24'd0, 24'd0, '{0, 0, 0, 1, 1, 12'd4095, 12'd4095});
        wait_empty();
        write_reg(REG_IMG_H, 16'd480);
        for (int phase = 0; phase < 8; phase++) begin
            wait_empty();
            case (phase)
                0: begin
                    write_reg(REG_COS_YAW, 16'd16384); write_reg(REG_SIN_YAW, 16'd0);
                    write_reg(REG_FOCAL_X, 16'd5120); write_reg(REG_FOCAL_Y, 16'd5120);
                    write_reg(REG_CENTER_X, 16'd5120); write_reg(REG_CENTER_Y, 16'd3840);
                    write_reg(REG_IMG_W, 16'd640); write_reg(REG_IMG_H, 16'd480);
                end
                1: begin
                    write_reg(REG_COS_YAW, 16'hC000); write_reg(REG_SIN_YAW, 16'h4000);
                end
                2: begin
                    write_reg(REG_COS_YAW, 16'd11585); write_reg(REG_SIN_YAW, 16'hD2BF);
                    write_reg(REG_FOCAL_X, 16'hFFFF); write_reg(REG_FOCAL_Y, 16'd0);
                    write_reg(REG_IMG_W, 16'd4096); write_reg(REG_IMG_H, 16'd1);
                end
                3: begin
                    write_reg(REG_COS_YAW, 16'h4000); write_reg(REG_SIN_YAW, 16'hC000);
                    write_reg(REG_FOCAL_X, 16'd0); write_reg(REG_FOCAL_Y, 16'hFFFF);
                    write_reg(REG_CENTER_X, 16'd0); write_reg(REG_IMG_W, 16'd1);
                    write_reg(REG_IMG_H, 16'd4096);
                end
                4: begin
                    no_idle = 1'b1;
                    write_reg(REG_FOCAL_X, 16'd8000); write_reg(REG_FOCAL_Y, 16'd8000);
                    write_reg(REG_CENTER_X, 16'd10240); write_reg(REG_CENTER_Y, 16'd7680);
                    write_reg(REG_IMG_W, 16'd1280); write_reg(REG_IMG_H, 16'd960);
                end
                default: begin
                    no_idle = 1'b0;
                    cfg = 16'($urandom_range(32768) - 16384);
                    write_reg(REG_COS_YAW, cfg);
                    write_reg(REG_SIN_YAW, 16'($urandom_range(32768) - 16384));
                    write_reg(REG_FOCAL_X, 16'($urandom_range(12000)));
                    write_reg(REG_FOCAL_Y, 16'($urandom_range(12000)));
                    write_reg(REG_CENTER_X, 16'($urandom));
                    write_reg(REG_CENTER_Y, 16'($urandom));
                    write_reg(REG_IMG_W, 16'($urandom_range(8191)));
                    write_reg(REG_IMG_H, 16'($urandom_range(8191)));
                end
            endcase
            if (phase == 5) begin
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (400) @(posedge i_clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            for (int n = 0; n < N_RANDOM / 8; n++) begin
                if ($urandom_range(9) < 8)
                    send_point(PT_W'($urandom_range(20000) + 400), near_coord(6000),
                               near_coord(2000), blank);
                else
                    send_point(PT_W'($urandom), PT_W'($urandom), PT_W'($urandom), blank);
            end
        end
        wait_empty();
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
